// File: hdl/fraex_pkg.sv
// Shared types, widths and operation codes for the four-register ALU executor.
package fraex_pkg;

   // Word and register file geometry.
   localparam int DATA_WIDTH      = 32;
   localparam int REG_INDEX_WIDTH = 2;
   localparam int REGISTER_COUNT  = 1 << REG_INDEX_WIDTH;
   localparam int SHAMT_WIDTH     = $clog2(DATA_WIDTH);
   localparam int MODE_WIDTH      = 4;

   typedef logic [DATA_WIDTH-1:0]      word_type;
   typedef logic [REG_INDEX_WIDTH-1:0] reg_index_type;
   typedef logic [MODE_WIDTH-1:0]      mode_type;

   // Operation codes; the remaining codes are unknown operations.
   localparam mode_type OP_ADD  = 4'd0;
   localparam mode_type OP_SUB  = 4'd1;
   localparam mode_type OP_AND  = 4'd2;
   localparam mode_type OP_OR   = 4'd3;
   localparam mode_type OP_XOR  = 4'd4;
   localparam mode_type OP_SLL  = 4'd5;
   localparam mode_type OP_SRL  = 4'd6;
   localparam mode_type OP_SRA  = 4'd7;
   localparam mode_type OP_SLT  = 4'd8;
   localparam mode_type OP_SLTU = 4'd9;

   // Write port of the register file.
   typedef struct packed {
      logic          enable;
      reg_index_type index;
      word_type      data;
   } rf_write_type;

   // Outcome of one ALU operation.
   typedef struct packed {
      logic     known;
      word_type value;
   } alu_result_type;

endpackage

// File: hdl/fraex_alu.sv
// Combinational integer ALU covering add, subtract, logic, shift and compare.
module fraex_alu (
   input  fraex_pkg::mode_type       mode,
   input  fraex_pkg::word_type       operand_a,
   input  fraex_pkg::word_type       operand_b,
   output fraex_pkg::alu_result_type result
);
   import fraex_pkg::*;

   logic [SHAMT_WIDTH-1:0] shamt;

   // The shift amount is the low bits of the second operand.
   assign shamt = operand_b[SHAMT_WIDTH-1:0];

   // Operation select; unknown codes give zero and clear the known flag.
   always_comb begin
      result.known = 1'b1;
      result.value = '0;
      unique case (mode)
         OP_ADD:  result.value = operand_a + operand_b;
         OP_SUB:  result.value = operand_a - operand_b;
         OP_AND:  result.value = operand_a & operand_b;
         OP_OR:   result.value = operand_a | operand_b;
         OP_XOR:  result.value = operand_a ^ operand_b;
         OP_SLL:  result.value = operand_a << shamt;
         OP_SRL:  result.value = operand_a >> shamt;
         OP_SRA:  result.value = word_type'($signed(operand_a) >>> shamt);
         OP_SLT:  result.value = {{(DATA_WIDTH-1){1'b0}},
                                  ($signed(operand_a) < $signed(operand_b))};
         OP_SLTU: result.value = {{(DATA_WIDTH-1){1'b0}}, (operand_a < operand_b)};
         default: result.known = 1'b0;
      endcase
   end

endmodule

// File: hdl/fraex_regfile.sv
// Register file with two read ports and one write port, cleared at reset.
module fraex_regfile (
   input  logic                    clock,
   input  logic                    reset,
   input  fraex_pkg::rf_write_type write_port,
   input  fraex_pkg::reg_index_type read_index_a,
   input  fraex_pkg::reg_index_type read_index_b,
   output fraex_pkg::word_type      read_data_a,
   output fraex_pkg::word_type      read_data_b
);
   import fraex_pkg::*;

   word_type regs_ff [REGISTER_COUNT];

   // Storage: cleared at reset, one word written per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (write_port.enable) begin
         regs_ff[write_port.index] <= write_port.data;
      end
   end

   // Asynchronous reads; every index names an existing register.
   assign read_data_a = regs_ff[read_index_a];
   assign read_data_b = regs_ff[read_index_b];

endmodule

// File: hdl/four_register_alu_executor_top.sv
// Top level of the four-register ALU executor: input register, ALU and result register.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  decoded instruction and literals
//   rsp_     out        rsp_valid/rsp_stall  written register, value, unknown flag
//
// A word is captured in the input register; while it waits there the register
// file is read and the ALU works; as the stage advances, the register file and
// the result register are written at the same edge. One word is accepted every
// cycle while req_stall is low; a word that follows reads the value left by the
// one before it. Reset (synchronous) clears the register file and both valid
// flags. A stall on the result side while a result waits holds the execute
// stage; req_stall rises once the input register also holds a word.
module four_register_alu_executor_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fraex_pkg::mode_type             req_mode,
   input  logic                            req_first_is_register,
   input  fraex_pkg::reg_index_type        req_first_register,
   input  logic signed [31:0]              req_first_literal,
   input  logic                            req_second_is_register,
   input  fraex_pkg::reg_index_type        req_second_register,
   input  logic signed [31:0]              req_second_literal,
   input  fraex_pkg::reg_index_type        req_target_register,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fraex_pkg::reg_index_type        rsp_written_register,
   output logic signed [31:0]              rsp_result_value,
   output logic                            rsp_unknown_operation
);
   import fraex_pkg::*;

   typedef struct packed {
      mode_type      mode;
      logic          first_is_register;
      reg_index_type first_register;
      word_type      first_literal;
      logic          second_is_register;
      reg_index_type second_register;
      word_type      second_literal;
      reg_index_type target_register;
   } instr_type;

   instr_type      instr_ff;
   logic           instr_valid_ff;
   logic           rsp_valid_ff;
   reg_index_type  rsp_register_ff;
   word_type       rsp_value_ff;
   logic           rsp_unknown_ff;

   logic           advance;
   word_type       read_data_a;
   word_type       read_data_b;
   word_type       operand_a;
   word_type       operand_b;
   alu_result_type alu_result;
   rf_write_type   write_port;

   // The execute stage moves on when the result register is free or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = instr_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         instr_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         instr_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         instr_ff.mode               <= req_mode;
         instr_ff.first_is_register  <= req_first_is_register;
         instr_ff.first_register     <= req_first_register;
         instr_ff.first_literal      <= word_type'(req_first_literal);
         instr_ff.second_is_register <= req_second_is_register;
         instr_ff.second_register    <= req_second_register;
         instr_ff.second_literal     <= word_type'(req_second_literal);
         instr_ff.target_register    <= req_target_register;
      end
   end

   fraex_regfile u_regfile (
      .clock        (clock),
      .reset        (reset),
      .write_port   (write_port),
      .read_index_a (instr_ff.first_register),
      .read_index_b (instr_ff.second_register),
      .read_data_a  (read_data_a),
      .read_data_b  (read_data_b)
   );

   // Operand selection between register reads and literals.
   assign operand_a = instr_ff.first_is_register  ? read_data_a : instr_ff.first_literal;
   assign operand_b = instr_ff.second_is_register ? read_data_b : instr_ff.second_literal;

   fraex_alu u_alu (
      .mode      (instr_ff.mode),
      .operand_a (operand_a),
      .operand_b (operand_b),
      .result    (alu_result)
   );

   // Write-back happens only for a known operation as the word leaves the stage.
   assign write_port.enable = instr_valid_ff && advance && alu_result.known;
   assign write_port.index  = instr_ff.target_register;
   assign write_port.data   = alu_result.value;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= instr_valid_ff;
      end
      if (advance && instr_valid_ff) begin
         rsp_register_ff <= alu_result.known ? instr_ff.target_register : '0;
         rsp_value_ff    <= alu_result.value;
         rsp_unknown_ff  <= !alu_result.known;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_written_register  = rsp_register_ff;
   assign rsp_result_value      = $signed(rsp_value_ff);
   assign rsp_unknown_operation = rsp_unknown_ff;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the four-register ALU executor.
module testbench;
   import fraex_pkg::*;

   localparam int       CLOCK_HALF    = 5;
   localparam int       HOLD_CYCLES   = 80;
   localparam int       SETTLE_CYCLES = 10;
   localparam int       REPORT_LIMIT  = 10;
   localparam int       RANDOM_WORDS  = 500;
   localparam mode_type MODE_LAST     = {MODE_WIDTH{1'b1}};
   localparam logic     FROM_REG      = 1'b1;
   localparam logic     FROM_LIT      = 1'b0;

   // One decoded instruction word as presented on the request side.
   typedef struct {
      mode_type      mode;
      logic          first_is_reg;
      reg_index_type first_reg;
      word_type      first_lit;
      logic          second_is_reg;
      reg_index_type second_reg;
      word_type      second_lit;
      reg_index_type target;
   } instruction_type;

   // One result word as expected on the response side.
   typedef struct {
      reg_index_type written;
      word_type      value;
      logic          unknown;
   } outcome_type;

   logic          clock                  = 1'b0;
   logic          reset                  = 1'b1;
   logic          req_valid              = 1'b0;
   mode_type      req_mode               = OP_ADD;
   logic          req_first_is_register  = 1'b0;
   reg_index_type req_first_register     = '0;
   word_type      req_first_literal      = '0;
   logic          req_second_is_register = 1'b0;
   reg_index_type req_second_register    = '0;
   word_type      req_second_literal     = '0;
   reg_index_type req_target_register    = '0;
   logic          rsp_stall              = 1'b0;

   logic               req_stall;
   logic               rsp_valid;
   reg_index_type      rsp_written_register;
   logic signed [31:0] rsp_result_value;
   logic               rsp_unknown_operation;

   // Shadow register file and the queue of results still to come.
   word_type    shadow_regs [REGISTER_COUNT];
   outcome_type pending_results [$];

   bit sender_gaps_on = 1'b1;
   bit stall_gaps_on  = 1'b1;
   bit hold_request   = 1'b0;

   int words_sent      = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int hold_count      = 0;
   int op_hits [16];

   four_register_alu_executor_top u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_mode               (req_mode),
      .req_first_is_register  (req_first_is_register),
      .req_first_register     (req_first_register),
      .req_first_literal      (req_first_literal),
      .req_second_is_register (req_second_is_register),
      .req_second_register    (req_second_register),
      .req_second_literal     (req_second_literal),
      .req_target_register    (req_target_register),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_written_register   (rsp_written_register),
      .rsp_result_value       (rsp_result_value),
      .rsp_unknown_operation  (rsp_unknown_operation)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Gap lengths: mostly none, some short, a few long.
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Executes one instruction on the shadow register file and returns its outcome.
   function automatic outcome_type execute_instruction(instruction_type ins);
      word_type                   a;
      word_type                   b;
      logic [SHAMT_WIDTH-1:0]     shift;
      outcome_type                res;
      a     = ins.first_is_reg ? shadow_regs[ins.first_reg] : ins.first_lit;
      b     = ins.second_is_reg ? shadow_regs[ins.second_reg] : ins.second_lit;
      shift = b[SHAMT_WIDTH-1:0];
      res.written = ins.target;
      res.unknown = 1'b0;
      case (ins.mode)
         OP_ADD:  res.value = a + b;
         OP_SUB:  res.value = a - b;
         OP_AND:  res.value = a & b;
         OP_OR:   res.value = a | b;
         OP_XOR:  res.value = a ^ b;
         OP_SLL:  res.value = a << shift;
         OP_SRL:  res.value = a >> shift;
         OP_SRA:  res.value = word_type'($signed(a) >>> shift);
         OP_SLT:  res.value = word_type'($signed(a) < $signed(b));
         OP_SLTU: res.value = word_type'(a < b);
         default: begin
            res.written = '0;
            res.value   = '0;
            res.unknown = 1'b1;
         end
      endcase
      // An unknown operation leaves the register file untouched.
      if (!res.unknown) shadow_regs[ins.target] = res.value;
      return res;
   endfunction

   function automatic instruction_type make_instr(mode_type m, logic fir, reg_index_type fr,
                                                  word_type fl, logic sir, reg_index_type sr,
                                                  word_type sl, reg_index_type t);
      instruction_type ins;
      ins.mode          = m;
      ins.first_is_reg  = fir;
      ins.first_reg     = fr;
      ins.first_lit     = fl;
      ins.second_is_reg = sir;
      ins.second_reg    = sr;
      ins.second_lit    = sl;
      ins.target        = t;
      return ins;
   endfunction

   // Literals lean towards corner values and small shift amounts.
   function automatic word_type pick_literal();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return 32'h8000_0000;
         4:       return 32'h7fff_ffff;
         5:       return $urandom_range(0, 63);
         default: return $urandom();
      endcase
   endfunction

   function automatic instruction_type random_instruction();
      instruction_type ins;
      if ($urandom_range(0, 9) == 0) ins.mode = mode_type'($urandom_range(OP_SLTU + 1, MODE_LAST));
      else ins.mode = mode_type'($urandom_range(OP_ADD, OP_SLTU));
      ins.first_is_reg  = 1'($urandom_range(0, 1));
      ins.first_reg     = reg_index_type'($urandom_range(0, REGISTER_COUNT - 1));
      ins.first_lit     = pick_literal();
      ins.second_is_reg = 1'($urandom_range(0, 1));
      ins.second_reg    = reg_index_type'($urandom_range(0, REGISTER_COUNT - 1));
      ins.second_lit    = pick_literal();
      ins.target        = reg_index_type'($urandom_range(0, REGISTER_COUNT - 1));
      return ins;
   endfunction

   // Offers one word, waits for it to be taken and records the expected result.
   // Valid is left high so that a following word can go out without a gap.
   task automatic send_instruction(input instruction_type ins);
      int gap;
      gap = sender_gaps_on ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_mode               <= ins.mode;
      req_first_is_register  <= ins.first_is_reg;
      req_first_register     <= ins.first_reg;
      req_first_literal      <= ins.first_lit;
      req_second_is_register <= ins.second_is_reg;
      req_second_register    <= ins.second_reg;
      req_second_literal     <= ins.second_lit;
      req_target_register    <= ins.target;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), execute_instruction(ins));
      op_hits[ins.mode]++;
      words_sent++;
   endtask

   // Lowers valid and waits until every outstanding result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Every operation at least once, with corner operands, forwarding and unknown codes.
   task automatic test_each_operation();
      send_instruction(make_instr(OP_ADD, FROM_REG, 2'd0, '0, FROM_REG, 2'd3, '0, 2'd1));
      send_instruction(make_instr(OP_ADD, FROM_LIT, 2'd0, 32'h7fff_ffff,
                                  FROM_LIT, 2'd0, 32'd1, 2'd0));
      send_instruction(make_instr(OP_SUB, FROM_LIT, 2'd0, 32'h8000_0000,
                                  FROM_LIT, 2'd0, 32'd1, 2'd2));
      send_instruction(make_instr(OP_SUB, FROM_REG, 2'd0, '0, FROM_REG, 2'd2, '0, 2'd3));
      send_instruction(make_instr(OP_AND, FROM_LIT, 2'd0, '1,
                                  FROM_LIT, 2'd0, 32'haaaa_aaaa, 2'd1));
      send_instruction(make_instr(OP_OR, FROM_REG, 2'd1, '0,
                                  FROM_LIT, 2'd0, 32'h5555_5555, 2'd1));
      send_instruction(make_instr(OP_XOR, FROM_REG, 2'd1, '0, FROM_LIT, 2'd0, '1, 2'd2));
      send_instruction(make_instr(OP_SLL, FROM_LIT, 2'd0, 32'd1, FROM_LIT, 2'd0, 32'd31, 2'd3));
      // Shift amounts above 31 use only their low five bits.
      send_instruction(make_instr(OP_SLL, FROM_LIT, 2'd0, '1, FROM_LIT, 2'd0, 32'd37, 2'd0));
      send_instruction(make_instr(OP_SRL, FROM_LIT, 2'd0, 32'h8000_0000,
                                  FROM_LIT, 2'd0, 32'd31, 2'd1));
      send_instruction(make_instr(OP_SRA, FROM_LIT, 2'd0, 32'h8000_0000,
                                  FROM_LIT, 2'd0, '1, 2'd2));
      send_instruction(make_instr(OP_SRA, FROM_LIT, 2'd0, 32'hf000_0000,
                                  FROM_LIT, 2'd0, 32'd4, 2'd3));
      send_instruction(make_instr(OP_SRL, FROM_REG, 2'd3, '0, FROM_LIT, 2'd0, '0, 2'd3));
      send_instruction(make_instr(OP_SLT, FROM_LIT, 2'd0, '1, FROM_LIT, 2'd0, 32'd1, 2'd0));
      send_instruction(make_instr(OP_SLTU, FROM_LIT, 2'd0, '1, FROM_LIT, 2'd0, 32'd1, 2'd1));
      send_instruction(make_instr(OP_SLT, FROM_LIT, 2'd0, 32'h8000_0000,
                                  FROM_LIT, 2'd0, 32'h7fff_ffff, 2'd2));
      send_instruction(make_instr(OP_SLTU, FROM_REG, 2'd0, '0, FROM_REG, 2'd0, '0, 2'd2));
      send_instruction(make_instr(mode_type'(OP_SLTU + 1), FROM_LIT, 2'd1, '1,
                                  FROM_LIT, 2'd2, '1, 2'd1));
      // An unknown code aimed at register 3 must leave it unchanged.
      send_instruction(make_instr(MODE_LAST, FROM_REG, 2'd3, '1, FROM_REG, 2'd3, '1, 2'd3));
      send_instruction(make_instr(OP_ADD, FROM_REG, 2'd3, '0, FROM_LIT, 2'd0, '0, 2'd0));
   endtask

   task automatic test_random_mix();
      repeat (RANDOM_WORDS) send_instruction(random_instruction());
   endtask

   // A stretch with no gaps on either side.
   task automatic test_back_to_back();
      sender_gaps_on = 1'b0;
      stall_gaps_on  = 1'b0;
      repeat (60) send_instruction(random_instruction());
      sender_gaps_on = 1'b1;
      stall_gaps_on  = 1'b1;
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_result_hold_off();
      sender_gaps_on = 1'b0;
      hold_request   = 1'b1;
      repeat (40) send_instruction(random_instruction());
      sender_gaps_on = 1'b1;
   endtask

   // The sender pauses until everything has drained, then resumes.
   task automatic test_drain_pause();
      wait_for_drain();
      repeat (30) send_instruction(random_instruction());
   endtask

   // Response-side stall: random gaps plus the long hold-off on request.
   initial begin : result_stall_driver
      int span;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_count++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_gaps_on && $urandom_range(0, 3) == 0) begin
            span = 1 + idle_span();
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Compares each result word taken with the oldest expectation.
   always @(posedge clock) begin : result_checker
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: reg %0d value %h unknown %b",
                        rsp_written_register, rsp_result_value, rsp_unknown_operation);
         end else begin
            want = pending_results.pop_front();
            if (rsp_written_register !== want.written || rsp_result_value !== want.value ||
                rsp_unknown_operation !== want.unknown) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: want reg %0d value %h unk %b, got reg %0d value %h unk %b",
                           want.written, want.value, want.unknown, rsp_written_register,
                           rsp_result_value, rsp_unknown_operation);
            end
         end
      end
   end

   initial begin : run_limit
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : sequencer
      int ops_covered;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      foreach (op_hits[i]) op_hits[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_each_operation();
      test_random_mix();
      test_back_to_back();
      test_result_hold_off();
      test_drain_pause();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      ops_covered = 0;
      for (int m = OP_ADD; m <= OP_SLTU; m++) if (op_hits[m] != 0) ops_covered++;
      $display("Run covered %0d words and %0d results, %0d of 10 operations, %0d long hold-offs.",
               words_sent, results_checked, ops_covered, hold_count);
      $display("Unknown-code words: %0d; mismatches: %0d.",
               words_sent - op_hits[OP_ADD] - op_hits[OP_SUB] - op_hits[OP_AND] -
               op_hits[OP_OR] - op_hits[OP_XOR] - op_hits[OP_SLL] - op_hits[OP_SRL] -
               op_hits[OP_SRA] - op_hits[OP_SLT] - op_hits[OP_SLTU], mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
